/* rtl/core/tcw_pkg.sv */
`default_nettype none
package tcw_pkg;

  localparam int MAX_COLS = 80;
  localparam int MAX_ROWS = 25;
  localparam int NCELLS   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(NCELLS);
  localparam int TAB_SPACES = 4;

  // action codes
  localparam logic [2:0] ACT_PUT   = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_MOVE  = 3'd2;
  localparam logic [2:0] ACT_BOX   = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] CFG_COLUMNS    = 2'd1;
  localparam logic [1:0] CFG_ROWS       = 2'd2;
  localparam logic [1:0] CFG_TRACKING   = 2'd3;

  // control characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    K_PUT, K_CLEAR, K_MOVE, K_BOX, K_READ, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic [6:0] col_end;
    logic [4:0] row_end;
    logic [7:0] box_color;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] hw_cursor_position;
    logic [15:0] scroll_count;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } res_t;

  function automatic logic [6:0] eff_cols(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MAX_COLS)) return 7'(MAX_COLS);
    return v;
  endfunction

  function automatic logic [4:0] eff_rows(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_ROWS)) return 5'(MAX_ROWS);
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tcw_front.sv */
`default_nettype none
module tcw_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [39:0]       in_tdata,
  input  wire  [2:0]        in_tuser,
  input  wire               hold,
  output logic              q_valid,
  input  wire               q_ready,
  output tcw_pkg::req_t     q_req
);
  import tcw_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       req_w;
  logic       push, pop;

  always_comb begin
    req_w.char_code = in_tdata[7:0];
    req_w.col       = in_tdata[14:8];
    req_w.row       = in_tdata[19:15];
    req_w.col_end   = in_tdata[26:20];
    req_w.row_end   = in_tdata[31:27];
    req_w.box_color = in_tdata[39:32];
    unique case (in_tuser)
      ACT_PUT:   req_w.kind = K_PUT;
      ACT_CLEAR: req_w.kind = K_CLEAR;
      ACT_MOVE:  req_w.kind = K_MOVE;
      ACT_BOX:   req_w.kind = K_BOX;
      ACT_READ:  req_w.kind = K_READ;
      default:   req_w.kind = K_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2) && !hold;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_req     = ent_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= req_w;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tcw_back.sv */
`default_nettype none
module tcw_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [1:0]        cfg_index,
  input  wire  [7:0]        cfg_data,
  input  wire               q_valid,
  output logic              q_ready,
  input  tcw_pkg::req_t     q_req,
  output logic              init_busy,
  output logic              res_valid,
  input  wire               res_ready,
  output tcw_pkg::res_t     res
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_WRAP, ST_BODY, ST_SC_RD, ST_SC_WR, ST_BLANK, ST_FILL,
    ST_BOX_RD, ST_BOX_WR, ST_RD_WAIT, ST_RD_CAP, ST_HW, ST_OUT
  } state_t;

  logic [15:0] mem [NCELLS];
  logic [15:0] rdata_r;

  state_t      state_r, ret_r;
  logic [7:0]  tc_r;
  logic [6:0]  cols_r;
  logic [4:0]  rows_r;
  logic        track_r;
  logic [6:0]  cur_col_r;
  logic [4:0]  cur_row_r;
  logic [10:0] hw_r;
  logic [15:0] scrolls_r;
  logic        moved_r;
  logic [7:0]  ch_r;
  logic [1:0]  cnt_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [4:0]  bi_r, r0_r, r1_r;
  logic [6:0]  bj_r, c0_r, c1_r;
  logic [7:0]  bc_r;
  logic [7:0]  rd_char_r, rd_attr_r;
  logic        res_valid_r;
  res_t        res_r;

  logic [6:0]  nc;
  logic [4:0]  nr;
  logic [ADDR_W-1:0] total, keep;
  logic [4:0]  a_row;
  logic [6:0]  a_col;
  logic [11:0] lin;
  logic        we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0] wdata, blank;
  logic        is_ctl;
  logic [6:0]  cl_c1;
  logic [4:0]  cl_r1;
  logic [6:0]  mv_c;
  logic [4:0]  mv_r;

  assign nc     = eff_cols(cols_r);
  assign nr     = eff_rows(rows_r);
  assign total  = ADDR_W'(12'(nr) * 12'(nc));
  assign keep   = total - ADDR_W'(nc);
  assign blank  = {tc_r, CH_SPACE};
  assign is_ctl = (ch_r == CH_LF) || (ch_r == CH_NUL) || (ch_r == CH_CR) || (ch_r == CH_BS);
  assign lin    = 12'(a_row) * 12'(nc) + 12'(a_col);

  assign cl_c1 = (q_req.col_end > nc) ? nc : q_req.col_end;
  assign cl_r1 = (q_req.row_end > nr) ? nr : q_req.row_end;
  assign mv_c  = (q_req.col > nc) ? nc : q_req.col;
  assign mv_r  = (q_req.row > nr - 5'd1) ? nr - 5'd1 : q_req.row;

  assign q_ready   = (state_r == ST_IDLE);
  assign init_busy = (state_r == ST_INIT);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // address selection for the shared row*cols+col unit
  always_comb begin
    a_row = cur_row_r;
    a_col = cur_col_r;
    case (state_r)
      ST_BODY: begin
        if (ch_r == CH_BS) begin
          if (cur_col_r == 7'd0) begin
            a_row = cur_row_r - 5'd1;
            a_col = nc - 7'd1;
          end else begin
            a_col = cur_col_r - 7'd1;
          end
        end
      end
      ST_BOX_RD, ST_BOX_WR: begin
        a_row = bi_r;
        a_col = bj_r;
      end
      ST_RD_WAIT: begin
        a_row = r0_r;
        a_col = c0_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = lin[ADDR_W-1:0];
    raddr = lin[ADDR_W-1:0];
    wdata = blank;
    case (state_r)
      ST_INIT: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = 16'd0;
      end
      ST_BODY: begin
        if (ch_r == CH_BS) begin
          we = (cur_col_r != 7'd0) || (cur_row_r != 5'd0);
        end else if (!is_ctl) begin
          we    = 1'b1;
          wdata = {tc_r, ch_r};
        end
      end
      ST_SC_RD: raddr = ptr_r + ADDR_W'(nc);
      ST_SC_WR: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = rdata_r;
      end
      ST_BLANK, ST_FILL: begin
        we    = 1'b1;
        waddr = ptr_r;
      end
      ST_BOX_WR: begin
        we    = 1'b1;
        wdata = {bc_r, rdata_r[7:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ret_r       <= ST_HW;
      tc_r        <= 8'd7;
      cols_r      <= 7'(MAX_COLS);
      rows_r      <= 5'(MAX_ROWS);
      track_r     <= 1'b1;
      cur_col_r   <= 7'd0;
      cur_row_r   <= 5'd0;
      hw_r        <= '0;
      scrolls_r   <= 16'd0;
      moved_r     <= 1'b0;
      ptr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TEXT_COLOR: tc_r <= cfg_data;
          CFG_COLUMNS: begin
            cols_r <= cfg_data[6:0];
            if (cur_col_r > eff_cols(cfg_data[6:0])) cur_col_r <= eff_cols(cfg_data[6:0]);
            if (cur_row_r > nr - 5'd1) cur_row_r <= nr - 5'd1;
          end
          CFG_ROWS: begin
            rows_r <= cfg_data[4:0];
            if (cur_col_r > nc) cur_col_r <= nc;
            if (cur_row_r > eff_rows(cfg_data[4:0]) - 5'd1)
              cur_row_r <= eff_rows(cfg_data[4:0]) - 5'd1;
          end
          CFG_TRACKING: track_r <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_INIT: begin
          ptr_r <= ptr_r + ADDR_W'(1);
          if (ptr_r == ADDR_W'(NCELLS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            moved_r   <= 1'b0;
            rd_char_r <= 8'd0;
            rd_attr_r <= 8'd0;
            c0_r      <= q_req.col;
            r0_r      <= q_req.row;
            bj_r      <= q_req.col;
            bi_r      <= q_req.row;
            c1_r      <= cl_c1;
            r1_r      <= cl_r1;
            bc_r      <= q_req.box_color;
            ptr_r     <= '0;
            unique case (q_req.kind)
              K_PUT: begin
                if (q_req.char_code == CH_TAB) begin
                  ch_r  <= CH_SPACE;
                  cnt_r <= 2'(TAB_SPACES - 1);
                end else begin
                  ch_r  <= q_req.char_code;
                  cnt_r <= 2'd0;
                end
                state_r <= ST_WRAP;
              end
              K_CLEAR: state_r <= ST_FILL;
              K_MOVE: begin
                cur_col_r <= mv_c;
                cur_row_r <= mv_r;
                moved_r   <= 1'b1;
                state_r   <= ST_HW;
              end
              K_BOX: begin
                if (q_req.row < cl_r1 && q_req.col < cl_c1) state_r <= ST_BOX_RD;
                else state_r <= ST_HW;
              end
              K_READ: begin
                if (q_req.col < nc && q_req.row < nr) state_r <= ST_RD_WAIT;
                else state_r <= ST_HW;
              end
              default: state_r <= ST_HW;
            endcase
          end
        end
        ST_WRAP: begin
          if (cur_col_r >= nc) begin
            if ({1'b0, cur_row_r} + 6'd1 >= {1'b0, nr}) begin
              ret_r   <= ST_BODY;
              ptr_r   <= '0;
              state_r <= (keep == '0) ? ST_BLANK : ST_SC_RD;
            end else begin
              cur_col_r <= 7'd0;
              cur_row_r <= cur_row_r + 5'd1;
              moved_r   <= 1'b1;
              state_r   <= ST_BODY;
            end
          end else begin
            state_r <= ST_BODY;
          end
        end
        ST_BODY: begin
          state_r <= ST_HW;
          case (ch_r)
            CH_LF: begin
              if ({1'b0, cur_row_r} + 6'd1 >= {1'b0, nr}) begin
                ret_r   <= ST_HW;
                ptr_r   <= '0;
                state_r <= (keep == '0) ? ST_BLANK : ST_SC_RD;
              end else begin
                cur_col_r <= 7'd0;
                cur_row_r <= cur_row_r + 5'd1;
                moved_r   <= 1'b1;
              end
            end
            CH_NUL: ;
            CH_CR: begin
              cur_col_r <= 7'd0;
              moved_r   <= 1'b1;
            end
            CH_BS: begin
              if (cur_col_r == 7'd0) begin
                if (cur_row_r != 5'd0) begin
                  cur_col_r <= nc - 7'd1;
                  cur_row_r <= cur_row_r - 5'd1;
                  moved_r   <= 1'b1;
                end
              end else begin
                cur_col_r <= cur_col_r - 7'd1;
                moved_r   <= 1'b1;
              end
            end
            default: begin
              cur_col_r <= cur_col_r + 7'd1;
              moved_r   <= 1'b1;
              if (cnt_r != 2'd0) begin
                cnt_r   <= cnt_r - 2'd1;
                state_r <= ST_WRAP;
              end
            end
          endcase
        end
        ST_SC_RD: state_r <= ST_SC_WR;
        ST_SC_WR: begin
          ptr_r   <= ptr_r + ADDR_W'(1);
          state_r <= (ptr_r == keep - ADDR_W'(1)) ? ST_BLANK : ST_SC_RD;
        end
        ST_BLANK: begin
          ptr_r <= ptr_r + ADDR_W'(1);
          if (ptr_r == total - ADDR_W'(1)) begin
            cur_col_r <= 7'd0;
            cur_row_r <= nr - 5'd1;
            moved_r   <= 1'b1;
            scrolls_r <= scrolls_r + 16'd1;
            state_r   <= ret_r;
          end
        end
        ST_FILL: begin
          ptr_r <= ptr_r + ADDR_W'(1);
          if (ptr_r == total - ADDR_W'(1)) begin
            cur_col_r <= 7'd0;
            cur_row_r <= 5'd0;
            moved_r   <= 1'b1;
            scrolls_r <= 16'd0;
            state_r   <= ST_HW;
          end
        end
        ST_BOX_RD: state_r <= ST_BOX_WR;
        ST_BOX_WR: begin
          state_r <= ST_BOX_RD;
          if (bj_r == c1_r - 7'd1) begin
            bj_r <= c0_r;
            bi_r <= bi_r + 5'd1;
            if (bi_r == r1_r - 5'd1) state_r <= ST_HW;
          end else begin
            bj_r <= bj_r + 7'd1;
          end
        end
        ST_RD_WAIT: state_r <= ST_RD_CAP;
        ST_RD_CAP: begin
          rd_char_r <= rdata_r[7:0];
          rd_attr_r <= rdata_r[15:8];
          state_r   <= ST_HW;
        end
        ST_HW: begin
          if (moved_r && track_r) hw_r <= lin[10:0];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid_r || res_ready) begin
            res_r.cursor_col         <= cur_col_r;
            res_r.cursor_row         <= cur_row_r;
            res_r.hw_cursor_position <= hw_r;
            res_r.scroll_count       <= scrolls_r;
            res_r.read_char          <= rd_char_r;
            res_r.read_attr          <= rd_attr_r;
            res_valid_r              <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/text_console_writer.sv */
`default_nettype none
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: request fields, tuser: action
// out_     out  out_tvalid/out_tready  tdata: cursor, hw cursor, scrolls, read cell
// cfg_     in   cfg_we                 cfg_index selects register, cfg_data value
//
// After reset a clearing pass zeroes the 2000-cell screen store;
// in_tready stays low meanwhile, configuration writes are taken as ever.
// A tab puts its further spaces one after another. A clear writes the cells
// in turn; a scroll reads then writes each kept cell and then blanks each cell
// of the new row; a box recolour reads then writes each cell of the box.
// A two-entry request queue and the output register let both sides stall.
module text_console_writer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [14:8] col, [19:15] row, [26:20] col_end,
  // [31:27] row_end, [39:32] box_color
  input  wire  [39:0] in_tdata,
  // [2:0] action
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [22:12] hw_cursor_position,
  // [38:23] scroll_count, [46:39] read_char, [54:47] read_attr, [55] zero
  output logic [55:0] out_tdata,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import tcw_pkg::*;

  logic  q_valid, q_ready, init_busy;
  req_t  q_req;
  res_t  res;

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .hold      (init_busy),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .init_busy (init_busy),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result, first field in the lowest bits
  assign out_tdata = {1'b0, res.read_attr, res.read_char, res.scroll_count,
                      res.hw_cursor_position, res.cursor_row, res.cursor_col};
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps a shadow of the console state and the queue of expected replies.
class console_scoreboard;
  logic [15:0] cells [tcw_pkg::NCELLS];
  int unsigned cur_c, cur_r, hw_pos, scroll_n;
  int unsigned colour, cols_reg, rows_reg, tracking;
  logic [55:0] pending_replies [$];
  int errors;

  function new();
    foreach (cells[i]) cells[i] = '0;
    cur_c = 0; cur_r = 0; hw_pos = 0; scroll_n = 0;
    colour = 7; cols_reg = 80; rows_reg = 25; tracking = 1;
    errors = 0;
  endfunction

  function int unsigned ncols();
    if (cols_reg < 1) return 1;
    if (cols_reg > tcw_pkg::MAX_COLS) return tcw_pkg::MAX_COLS;
    return cols_reg;
  endfunction

  function int unsigned nrows();
    if (rows_reg < 1) return 1;
    if (rows_reg > tcw_pkg::MAX_ROWS) return tcw_pkg::MAX_ROWS;
    return rows_reg;
  endfunction

  function logic [15:0] blank();
    return {colour[7:0], tcw_pkg::CH_SPACE};
  endfunction

  function void goto_cell(int unsigned c, int unsigned r);
    cur_c = c; cur_r = r;
    if (tracking[0]) hw_pos = (r * ncols() + c) & 11'h7ff;
  endfunction

  function void poke(int unsigned c, int unsigned r, logic [7:0] ch);
    int unsigned idx;
    idx = r * ncols() + c;
    if (idx < tcw_pkg::NCELLS) cells[idx] = {colour[7:0], ch};
  endfunction

  function void scroll();
    int unsigned nc, keep;
    nc = ncols();
    keep = nc * (nrows() - 1);
    for (int unsigned i = 0; i < keep; i++) cells[i] = cells[i + nc];
    for (int unsigned i = 0; i < nc; i++) cells[keep + i] = blank();
    goto_cell(0, nrows() - 1);
    scroll_n = (scroll_n + 1) & 16'hffff;
  endfunction

  function void line_feed();
    if (cur_r + 1 >= nrows()) scroll();
    else goto_cell(0, cur_r + 1);
  endfunction

  function void emit(logic [7:0] ch);
    if (cur_c >= ncols()) line_feed();
    poke(cur_c, cur_r, ch);
    goto_cell(cur_c + 1, cur_r);
  endfunction

  function void saturate_cursor();
    if (cur_c > ncols()) cur_c = ncols();
    if (cur_r > nrows() - 1) cur_r = nrows() - 1;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] v);
    case (idx)
      tcw_pkg::CFG_TEXT_COLOR: colour = v;
      tcw_pkg::CFG_COLUMNS: begin cols_reg = v[6:0]; saturate_cursor(); end
      tcw_pkg::CFG_ROWS: begin rows_reg = v[4:0]; saturate_cursor(); end
      tcw_pkg::CFG_TRACKING: tracking = v[0];
      default: ;
    endcase
  endfunction

  // Note an accepted request and queue the reply it must produce.
  function void note_request(logic [2:0] act, logic [39:0] d);
    logic [7:0] ch, bc, rch, rat;
    int unsigned c, r, ce, re, idx, n;
    ch = d[7:0]; c = d[14:8]; r = d[19:15]; ce = d[26:20]; re = d[31:27]; bc = d[39:32];
    rch = '0; rat = '0;
    case (act)
      tcw_pkg::ACT_PUT: begin
        if (cur_c >= ncols()) line_feed();
        case (ch)
          tcw_pkg::CH_LF: line_feed();
          tcw_pkg::CH_NUL: ;
          tcw_pkg::CH_BS: begin
            if (cur_c == 0) begin
              if (cur_r != 0) begin
                goto_cell(ncols() - 1, cur_r - 1);
                poke(cur_c, cur_r, tcw_pkg::CH_SPACE);
              end
            end else begin
              poke(cur_c - 1, cur_r, tcw_pkg::CH_SPACE);
              goto_cell(cur_c - 1, cur_r);
            end
          end
          tcw_pkg::CH_TAB: for (int k = 0; k < tcw_pkg::TAB_SPACES; k++) emit(tcw_pkg::CH_SPACE);
          tcw_pkg::CH_CR: goto_cell(0, cur_r);
          default: emit(ch);
        endcase
      end
      tcw_pkg::ACT_CLEAR: begin
        n = ncols() * nrows();
        for (int unsigned i = 0; i < n && i < tcw_pkg::NCELLS; i++) cells[i] = blank();
        goto_cell(0, 0);
        scroll_n = 0;
      end
      tcw_pkg::ACT_MOVE: begin
        if (c > ncols()) c = ncols();
        if (r > nrows() - 1) r = nrows() - 1;
        goto_cell(c, r);
      end
      tcw_pkg::ACT_BOX: begin
        if (ce > ncols()) ce = ncols();
        if (re > nrows()) re = nrows();
        for (int unsigned i = r; i < re; i++)
          for (int unsigned j = c; j < ce; j++) begin
            idx = i * ncols() + j;
            if (idx < tcw_pkg::NCELLS) cells[idx][15:8] = bc;
          end
      end
      tcw_pkg::ACT_READ: begin
        if (c < ncols() && r < nrows()) begin
          idx = r * ncols() + c;
          if (idx < tcw_pkg::NCELLS) begin
            rch = cells[idx][7:0];
            rat = cells[idx][15:8];
          end
        end
      end
      default: ;
    endcase
    pending_replies.push_back({1'b0, rat, rch, scroll_n[15:0], hw_pos[10:0],
                               cur_r[4:0], cur_c[6:0]});
  endfunction

  function void report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endfunction

  function void check_reply(logic [55:0] got);
    logic [55:0] want;
    if (pending_replies.size() == 0) begin
      report("unexpected reply", got[31:0], 0);
      return;
    end
    want = pending_replies.pop_front();
    if (got[6:0] !== want[6:0]) report("cursor_col", got[6:0], want[6:0]);
    if (got[11:7] !== want[11:7]) report("cursor_row", got[11:7], want[11:7]);
    if (got[22:12] !== want[22:12]) report("hw_cursor", got[22:12], want[22:12]);
    if (got[38:23] !== want[38:23]) report("scroll_count", got[38:23], want[38:23]);
    if (got[46:39] !== want[46:39]) report("read_char", got[46:39], want[46:39]);
    if (got[54:47] !== want[54:47]) report("read_attr", got[54:47], want[54:47]);
  endfunction
endclass

module testbench;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;  // clear pass after reset plus a full clear walk
  localparam int TAIL_CYCLES = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  console_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  bit timed_out;

  text_console_writer dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stall, check every accepted reply.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reply(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on stretches with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One request; valid stays high across back-to-back requests.
  task automatic send_request(logic [2:0] act, logic [39:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(act, d);
  endtask

  task automatic pack_send(logic [2:0] act, logic [7:0] ch, logic [6:0] c, logic [4:0] r,
                           logic [6:0] ce, logic [4:0] re, logic [7:0] bc);
    send_request(act, {bc, re, ce, r, c, ch});
  endtask

  // Registers only change with the block idle.
  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, v);
  endtask

  // Random character bytes, a quarter redrawn as a control code or printable; box bounds span the full fields.
  task automatic random_request();
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    ch = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(5))
        0: ch = CH_LF;
        1: ch = CH_BS;
        2: ch = CH_TAB;
        3: ch = CH_CR;
        4: ch = CH_NUL;
        default: ch = 8'($urandom_range(126, 32));
      endcase
    end
    if (pick < 60)
      pack_send(ACT_PUT, ch, 7'($urandom), 5'($urandom), 7'($urandom), 5'($urandom),
                8'($urandom));
    else if (pick < 61)
      pack_send(ACT_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 7'($urandom),
                5'($urandom), 8'($urandom));
    else if (pick < 73)
      pack_send(ACT_MOVE, ch, 7'($urandom_range(127)), 5'($urandom_range(31)),
                7'($urandom), 5'($urandom), 8'($urandom));
    else if (pick < 80)
      pack_send(ACT_BOX, ch, 7'($urandom_range(127)), 5'($urandom_range(31)),
                7'($urandom_range(127)), 5'($urandom_range(31)), 8'($urandom));
    else if (pick < 97)
      pack_send(ACT_READ, ch, 7'($urandom_range(85)), 5'($urandom_range(26)),
                7'($urandom), 5'($urandom), 8'($urandom));
    else
      pack_send(3'($urandom_range(7, 5)), 8'($urandom), 7'($urandom), 5'($urandom),
                7'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) random_request();
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: controls, wrap, backspace repairs, scroll, clipping, every action.
    pack_send(ACT_PUT, CH_BS, 0, 0, 0, 0, 0);           // backspace at top-left
    pack_send(ACT_READ, 0, 0, 0, 0, 0, 0);
    pack_send(ACT_PUT, 8'hff, 0, 0, 0, 0, 0);
    pack_send(ACT_PUT, CH_TAB, 0, 0, 0, 0, 0);
    pack_send(ACT_PUT, CH_CR, 0, 0, 0, 0, 0);
    pack_send(ACT_PUT, CH_NUL, 0, 0, 0, 0, 0);
    pack_send(ACT_MOVE, 0, 7'd127, 5'd31, 0, 0, 0);      // saturates to pending wrap
    pack_send(ACT_PUT, 8'h41, 0, 0, 0, 0, 0);            // wrap past last row scrolls
    pack_send(ACT_MOVE, 0, 0, 5'd3, 0, 0, 0);
    pack_send(ACT_PUT, CH_BS, 0, 0, 0, 0, 0);            // backspace across a line
    pack_send(ACT_READ, 0, 7'd79, 5'd2, 0, 0, 0);
    pack_send(ACT_MOVE, 0, 7'd80, 5'd5, 0, 0, 0);
    pack_send(ACT_PUT, CH_LF, 0, 0, 0, 0, 0);
    pack_send(ACT_BOX, 0, 7'd70, 5'd20, 7'd127, 5'd31, 8'hff);
    pack_send(ACT_BOX, 0, 7'd10, 5'd10, 7'd5, 5'd5, 8'h55);  // empty box
    pack_send(ACT_READ, 0, 7'd79, 5'd24, 0, 0, 0);
    pack_send(ACT_READ, 0, 7'd80, 5'd25, 0, 0, 0);       // outside screen
    pack_send(3'd7, 8'hff, 7'd127, 5'd31, 7'd127, 5'd31, 8'hff);
    pack_send(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    pack_send(ACT_READ, 0, 7'd5, 5'd5, 0, 0, 0);

    // Geometry and colour settings, extremes included; small screens scroll a lot.
    write_reg(CFG_TEXT_COLOR, 8'hff);
    write_reg(CFG_COLUMNS, 8'd0);
    write_reg(CFG_ROWS, 8'd0);
    write_reg(CFG_TRACKING, 8'd0);
    random_phase(150, 19, 86);
    write_reg(CFG_COLUMNS, 8'd127);
    write_reg(CFG_ROWS, 8'd31);
    write_reg(CFG_TRACKING, 8'd1);
    write_reg(CFG_TEXT_COLOR, 8'h00);
    random_phase(250, 19, 86);
    write_reg(CFG_COLUMNS, 8'd8);
    write_reg(CFG_ROWS, 8'd4);
    write_reg(CFG_TEXT_COLOR, 8'h5a);
    random_phase(500, 86, 19);
    write_reg(CFG_COLUMNS, 8'd17);
    write_reg(CFG_ROWS, 8'd3);
    write_reg(CFG_TRACKING, 8'hfe);
    random_phase(450, 86, 19);
    write_reg(CFG_COLUMNS, 8'd80);
    write_reg(CFG_ROWS, 8'd25);
    write_reg(CFG_TRACKING, 8'd1);
    write_reg(CFG_TEXT_COLOR, 8'h1e);
    random_phase(580, 0, 0);

    in_tvalid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* text_console_writer.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
verif/testbench.sv
